[rtl/fcs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcs_pkg
// Shared types, codes and constants of the frame crossfade sequencer.
// ----------------------------------------------------------------------------
package fcs_pkg;

  localparam int LAYER_COUNT_DEFAULT = 8;
  localparam int CHANNELS_DEFAULT    = 192;
  localparam int BANK_COUNT          = 3;

  localparam int LEVEL_W = 8;
  localparam int DUR_W   = 16;
  localparam int TIME_W  = 32;
  localparam int COUNT_W = 32;

  // Blend weight resolution: the weight is an 8-bit fraction of 256.
  localparam int P_BITS = 8;
  localparam int CNT_W  = $clog2(P_BITS);

  localparam logic [DUR_W-1:0] LIMIT_RESET = 16'd80;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_STREAM_ENABLE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSITION_LIMIT = 1'd1;

  localparam logic [1:0] BANK_RESET_SHOWN   = 2'd0;
  localparam logic [1:0] BANK_RESET_PENDING = 2'd1;
  localparam logic [1:0] BANK_RESET_STAGING = 2'd2;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_COMMIT = 2'd1,
    OP_RENDER = 2'd2,
    OP_CLEAR  = 2'd3
  } fcs_op_e;

  typedef struct packed {
    fcs_op_e              op;
    logic [2:0]           layer;
    logic [7:0]           channel;
    logic [LEVEL_W-1:0]   level;
    logic [DUR_W-1:0]     duration_ms;
    logic [TIME_W-1:0]    now_ms;
  } fcs_in_t;

  typedef struct packed {
    logic [LEVEL_W-1:0]   out_level;
    logic                 rendered;
    logic [COUNT_W-1:0]   frame_total;
  } fcs_out_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic rd_en;
    logic rd_pending;
    logic cap_a;
    logic cap_b;
    logic set_direct;
    logic div_init;
    logic div_step;
    logic blend;
    logic out_load;
  } fcs_cmd_t;

  typedef struct packed {
    fcs_op_e op;
    logic    render_ok;
    logic    index_ok;
    logic    need_blend;
    logic    out_free;
  } fcs_status_t;

endpackage

[rtl/fcs_stream_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcs_stream_if
// Valid/ready channel carrying one payload word per request.
// ----------------------------------------------------------------------------
interface fcs_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[rtl/frame_crossfade_sequencer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_crossfade_sequencer
// Three-bank LED frame store with timed commit and linear crossfade render.
// ----------------------------------------------------------------------------
// Requests are worked one at a time. Load, commit, clear and failed renders
// execute, then load the result once the result register is free; only then
// is the next request taken. Render without blend first does two reads on one
// RAM port; a render with blend also runs the 8-step serial divider and blend.
// Reset clears roles, flags, timing and the commit count; level memory is not
// cleared and holds undefined data until loaded.
module frame_crossfade_sequencer
  import fcs_pkg::*;
#(
  parameter int LAYER_COUNT = LAYER_COUNT_DEFAULT,
  parameter int CHANNELS    = CHANNELS_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  fcs_stream_if.sink           in_i,
  fcs_stream_if.source         out_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DUR_W-1:0]     cfg_data_i
);
  fcs_cmd_t    cmd;
  fcs_status_t status;
  logic        in_ready;
  logic        out_valid;
  fcs_out_t    out_payload;

  fcs_controller u_controller (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  fcs_datapath #(
    .LAYER_COUNT (LAYER_COUNT),
    .CHANNELS    (CHANNELS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_payload_i  (in_i.payload),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_valid),
    .out_payload_o (out_payload),
    .cmd_i         (cmd),
    .status_o      (status)
  );

  assign in_i.ready    = in_ready;
  assign out_o.valid   = out_valid;
  assign out_o.payload = out_payload;
endmodule

[rtl/fcs_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcs_ram
// Generic RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module fcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4608
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule

[rtl/fcs_controller.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcs_controller
// Sequencer that steps each request through execute, reads, divide and blend.
// ----------------------------------------------------------------------------
module fcs_controller
  import fcs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  fcs_status_t status_i,
  output fcs_cmd_t    cmd_o
);
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RD_A,
    S_RD_B,
    S_CAP_B,
    S_DIV,
    S_BLEND,
    S_DONE
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = (state_q == S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        if (status_i.op == OP_RENDER && status_i.render_ok && status_i.index_ok) begin
          state_d = S_RD_A;
        end else begin
          state_d = S_DONE;
        end
      end
      S_RD_A: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_RD_B;
      end
      S_RD_B: begin
        // The shown level arrives while the pending read is issued.
        cmd_o.rd_en      = 1'b1;
        cmd_o.rd_pending = 1'b1;
        cmd_o.cap_a      = 1'b1;
        state_d          = S_CAP_B;
      end
      S_CAP_B: begin
        cmd_o.cap_b = 1'b1;
        if (status_i.need_blend) begin
          cmd_o.div_init = 1'b1;
          cnt_d          = '0;
          state_d        = S_DIV;
        end else begin
          cmd_o.set_direct = 1'b1;
          state_d          = S_DONE;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == CNT_W'(P_BITS - 1)) begin
          state_d = S_BLEND;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_BLEND: begin
        cmd_o.blend = 1'b1;
        state_d     = S_DONE;
      end
      S_DONE: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end
endmodule

[rtl/fcs_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcs_datapath
// Bank roles, frame timing, level memory, serial divider, blend and result.
// ----------------------------------------------------------------------------
module fcs_datapath
  import fcs_pkg::*;
#(
  parameter int LAYER_COUNT = LAYER_COUNT_DEFAULT,
  parameter int CHANNELS    = CHANNELS_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DUR_W-1:0]     cfg_data_i,
  input  fcs_in_t              in_payload_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output fcs_out_t             out_payload_o,
  input  fcs_cmd_t             cmd_i,
  output fcs_status_t          status_o
);
  localparam int BANK_SIZE = LAYER_COUNT * CHANNELS;
  localparam int DEPTH     = BANK_COUNT * BANK_SIZE;
  localparam int AW        = $clog2(DEPTH);

  function automatic logic [AW-1:0] bank_base(input logic [1:0] bank);
    logic [AW-1:0] base;
    case (bank)
      2'd0:    base = '0;
      2'd1:    base = AW'(BANK_SIZE);
      default: base = AW'(2 * BANK_SIZE);
    endcase
    return base;
  endfunction

  // Configuration
  logic               stream_enable_q;
  logic [DUR_W-1:0]   limit_q;

  // Frame state
  logic [1:0]         shown_bank_q, pending_bank_q, staging_bank_q;
  logic               shown_valid_q, pending_valid_q;
  logic [DUR_W-1:0]   shown_dur_q, pending_dur_q;
  logic [TIME_W-1:0]  phase_start_q;
  logic [COUNT_W-1:0] commit_count_q;

  // Request and working registers
  fcs_in_t            item_q;
  logic [LEVEL_W-1:0] a_q, b_q;
  logic [DUR_W-1:0]   rem_q;
  logic [P_BITS-1:0]  quo_q;
  logic [LEVEL_W-1:0] res_level_q;
  logic               res_rendered_q;
  logic               out_valid_q;
  fcs_out_t           out_q;

  logic [AW-1:0]      offset;
  logic               index_ok;
  logic [TIME_W-1:0]  elapsed;
  logic [DUR_W-1:0]   step_cur;
  logic [DUR_W-1:0]   commit_dur;
  logic [DUR_W-1:0]   trans;
  logic               blend_on;
  logic               advance;
  logic               render_ok;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [AW-1:0]      ram_raddr;
  logic [LEVEL_W-1:0] ram_rdata;
  logic [DUR_W:0]     rem_dbl;
  logic               rem_ge;
  logic [P_BITS:0]    weight;
  logic [17:0]        mixed;

  assign offset   = AW'(int'(item_q.layer) * CHANNELS + int'(item_q.channel));
  assign index_ok = (int'(item_q.layer) < LAYER_COUNT) && (int'(item_q.channel) < CHANNELS);

  assign elapsed    = item_q.now_ms - phase_start_q;
  assign step_cur   = (shown_dur_q == '0) ? DUR_W'(1) : shown_dur_q;
  assign commit_dur = (item_q.duration_ms == '0) ? DUR_W'(1) : item_q.duration_ms;
  assign trans      = (limit_q > step_cur) ? step_cur : limit_q;
  assign blend_on   = pending_valid_q && (trans != '0);
  assign advance    = pending_valid_q && (elapsed >= {16'd0, step_cur});
  assign render_ok  = stream_enable_q && shown_valid_q;

  assign status_o.op         = item_q.op;
  assign status_o.render_ok  = render_ok;
  assign status_o.index_ok   = index_ok;
  assign status_o.need_blend = blend_on && (elapsed < {16'd0, trans});
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  assign ram_we    = cmd_i.exec && (item_q.op == OP_LOAD) && index_ok;
  assign ram_waddr = bank_base(staging_bank_q) + offset;
  assign ram_raddr = bank_base(cmd_i.rd_pending ? pending_bank_q : shown_bank_q) + offset;

  fcs_ram #(
    .WIDTH (LEVEL_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (item_q.level),
    .re_i    (cmd_i.rd_en),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // One restoring step per cycle; the remainder always stays below trans.
  assign rem_dbl = {rem_q, 1'b0};
  assign rem_ge  = rem_dbl >= {1'b0, trans};

  assign weight = {1'b0, quo_q};
  assign mixed  = 18'(a_q) * (18'd256 - 18'(weight)) + 18'(b_q) * 18'(weight) + 18'd128;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stream_enable_q <= 1'b0;
      limit_q         <= LIMIT_RESET;
      shown_bank_q    <= BANK_RESET_SHOWN;
      pending_bank_q  <= BANK_RESET_PENDING;
      staging_bank_q  <= BANK_RESET_STAGING;
      shown_valid_q   <= 1'b0;
      pending_valid_q <= 1'b0;
      shown_dur_q     <= '0;
      pending_dur_q   <= '0;
      phase_start_q   <= '0;
      commit_count_q  <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_STREAM_ENABLE:    stream_enable_q <= cfg_data_i[0];
          CFG_TRANSITION_LIMIT: limit_q         <= cfg_data_i;
          default: ;
        endcase
      end

      if (cmd_i.exec) begin
        case (item_q.op)
          OP_COMMIT: begin
            if (!shown_valid_q) begin
              staging_bank_q  <= shown_bank_q;
              shown_bank_q    <= staging_bank_q;
              shown_dur_q     <= commit_dur;
              shown_valid_q   <= 1'b1;
              pending_valid_q <= 1'b0;
              phase_start_q   <= item_q.now_ms;
            end else begin
              staging_bank_q  <= pending_bank_q;
              pending_bank_q  <= staging_bank_q;
              pending_dur_q   <= commit_dur;
              pending_valid_q <= 1'b1;
            end
            commit_count_q <= commit_count_q + 1'b1;
          end
          OP_RENDER: begin
            if (render_ok && advance) begin
              shown_bank_q    <= pending_bank_q;
              pending_bank_q  <= shown_bank_q;
              shown_dur_q     <= pending_dur_q;
              pending_valid_q <= 1'b0;
              phase_start_q   <= phase_start_q + {16'd0, step_cur};
            end
          end
          OP_CLEAR: begin
            shown_valid_q   <= 1'b0;
            pending_valid_q <= 1'b0;
            shown_dur_q     <= '0;
            pending_dur_q   <= '0;
            phase_start_q   <= '0;
            commit_count_q  <= '0;
            shown_bank_q    <= BANK_RESET_SHOWN;
            pending_bank_q  <= BANK_RESET_PENDING;
            staging_bank_q  <= BANK_RESET_STAGING;
          end
          default: ;
        endcase
      end

      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_payload_i;
    end
    if (cmd_i.exec) begin
      res_level_q    <= '0;
      res_rendered_q <= (item_q.op == OP_RENDER) && render_ok;
    end
    if (cmd_i.cap_a) begin
      a_q <= ram_rdata;
    end
    if (cmd_i.cap_b) begin
      b_q <= ram_rdata;
    end
    if (cmd_i.set_direct) begin
      res_level_q <= blend_on ? ram_rdata : a_q;
    end
    if (cmd_i.div_init) begin
      rem_q <= elapsed[DUR_W-1:0];
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_ge ? DUR_W'(rem_dbl - {1'b0, trans}) : rem_dbl[DUR_W-1:0];
      quo_q <= {quo_q[P_BITS-2:0], rem_ge};
    end
    if (cmd_i.blend) begin
      res_level_q <= mixed[15:8];
    end
    if (cmd_i.out_load) begin
      out_q.out_level   <= res_level_q;
      out_q.rendered    <= res_rendered_q;
      out_q.frame_total <= commit_count_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_payload_o = out_q;
endmodule

[rtl/fcs_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcs_checker
// Port-level checks of the frame crossfade sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module fcs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [7:0]  out_level_i,
  input logic        out_rendered_i,
  input logic [31:0] out_frame_total_i
);
  // A waiting result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result request dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_level_i) && $stable(out_rendered_i)
      && $stable(out_frame_total_i))
    else $error("result payload changed while stalled");

  // Requests are worked one at a time, so ready falls right after an accept.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second request accepted while one is in progress");

  // Only a successful render carries a level.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_rendered_i |-> out_level_i == 8'd0)
    else $error("level reported on a result that did not render");
endmodule

bind frame_crossfade_sequencer fcs_checker u_fcs_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .out_level_i       (out_o.payload.out_level),
  .out_rendered_i    (out_o.payload.rendered),
  .out_frame_total_i (out_o.payload.frame_total)
);

[tb/sv/frame_crossfade_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_crossfade_checker
// Watches the request, result and register ports of the frame crossfade
// sequencer and keeps its own copy of the bank store, roles, timing and
// registers. Every accepted request adds its expected result to a queue, and
// every accepted result is compared field by field with the oldest entry.
// ----------------------------------------------------------------------------
module frame_crossfade_checker
  import fcs_pkg::*;
#(
  parameter int LAYER_COUNT = LAYER_COUNT_DEFAULT,
  parameter int CHANNELS    = CHANNELS_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  input  logic                 req_ready_i,
  input  fcs_in_t              req_i,
  input  logic                 res_valid_i,
  input  logic                 res_ready_i,
  input  fcs_out_t             res_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DUR_W-1:0]     cfg_data_i,
  output int                   fail_count_o,
  output int                   open_count_o,
  output int                   checked_count_o,
  output int                   blend_count_o
);

  localparam int BANK_SIZE = LAYER_COUNT * CHANNELS;

  logic [LEVEL_W-1:0] level_mem [BANK_COUNT*BANK_SIZE];
  logic [1:0]         shown_bank;
  logic [1:0]         pending_bank;
  logic [1:0]         staging_bank;
  logic               shown_ok;
  logic               pending_ok;
  logic [DUR_W-1:0]   shown_dur;
  logic [DUR_W-1:0]   pending_dur;
  logic [TIME_W-1:0]  phase_start;
  logic [COUNT_W-1:0] commit_total;
  logic               stream_on;
  logic [DUR_W-1:0]   limit_ms;

  fcs_out_t expected_results [$];
  int       errors;
  int       checked;
  int       blends;

  function automatic bit index_ok(input logic [2:0] layer, input logic [7:0] channel);
    return (int'(layer) < LAYER_COUNT) && (int'(channel) < CHANNELS);
  endfunction

  function automatic int level_addr(input logic [1:0] bank, input logic [2:0] layer,
                                    input logic [7:0] channel);
    return int'(bank) * BANK_SIZE + int'(layer) * CHANNELS + int'(channel);
  endfunction

  function automatic fcs_out_t predict_result(input fcs_in_t req);
    fcs_out_t           res;
    logic [1:0]         bank_tmp;
    logic [DUR_W-1:0]   dur;
    logic [TIME_W-1:0]  step;
    logic [TIME_W-1:0]  elapsed;
    logic [TIME_W-1:0]  span;
    logic [TIME_W-1:0]  weight;
    logic [TIME_W-1:0]  mix;
    logic [LEVEL_W-1:0] lvl_a;
    logic [LEVEL_W-1:0] lvl_b;
    res = '0;
    case (req.op)
      OP_LOAD: begin
        if (index_ok(req.layer, req.channel)) begin
          level_mem[level_addr(staging_bank, req.layer, req.channel)] = req.level;
        end
      end
      OP_COMMIT: begin
        dur      = (req.duration_ms == '0) ? 16'd1 : req.duration_ms;
        bank_tmp = staging_bank;
        if (!shown_ok) begin
          staging_bank = shown_bank;
          shown_bank   = bank_tmp;
          shown_dur    = dur;
          shown_ok     = 1'b1;
          pending_ok   = 1'b0;
          phase_start  = req.now_ms;
        end else begin
          staging_bank = pending_bank;
          pending_bank = bank_tmp;
          pending_dur  = dur;
          pending_ok   = 1'b1;
        end
        commit_total = commit_total + 1'b1;
      end
      OP_RENDER: begin
        if (stream_on && shown_ok) begin
          res.rendered = 1'b1;
          step    = (shown_dur == '0) ? 32'd1 : {16'd0, shown_dur};
          elapsed = req.now_ms - phase_start;
          // The shown frame has run its time: the pending frame takes over.
          if (pending_ok && elapsed >= step) begin
            bank_tmp     = shown_bank;
            shown_bank   = pending_bank;
            pending_bank = bank_tmp;
            shown_dur    = pending_dur;
            pending_ok   = 1'b0;
            phase_start  = phase_start + step;
            step         = (shown_dur == '0) ? 32'd1 : {16'd0, shown_dur};
            elapsed      = req.now_ms - phase_start;
          end
          if (index_ok(req.layer, req.channel)) begin
            lvl_a = level_mem[level_addr(shown_bank, req.layer, req.channel)];
            lvl_b = level_mem[level_addr(pending_bank, req.layer, req.channel)];
            span  = ({16'd0, limit_ms} > step) ? step : {16'd0, limit_ms};
            if (!pending_ok || span == '0) begin
              res.out_level = lvl_a;
            end else if (elapsed >= span) begin
              res.out_level = lvl_b;
            end else begin
              weight = (elapsed * 32'd256) / span;
              mix    = {24'd0, lvl_a} * (32'd256 - weight) + {24'd0, lvl_b} * weight + 32'd128;
              res.out_level = mix[15:8];
              blends++;
            end
          end
        end
      end
      OP_CLEAR: begin
        shown_ok     = 1'b0;
        pending_ok   = 1'b0;
        shown_dur    = '0;
        pending_dur  = '0;
        phase_start  = '0;
        commit_total = '0;
        shown_bank   = BANK_RESET_SHOWN;
        pending_bank = BANK_RESET_PENDING;
        staging_bank = BANK_RESET_STAGING;
      end
      default: ;
    endcase
    res.frame_total = commit_total;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (act_val !== exp_val) begin
      errors++;
      if (errors <= 50) begin
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_val, act_val);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    fcs_out_t exp_res;
    if (!rst_ni) begin
      shown_bank   = BANK_RESET_SHOWN;
      pending_bank = BANK_RESET_PENDING;
      staging_bank = BANK_RESET_STAGING;
      shown_ok     = 1'b0;
      pending_ok   = 1'b0;
      shown_dur    = '0;
      pending_dur  = '0;
      phase_start  = '0;
      commit_total = '0;
      stream_on    = 1'b0;
      limit_ms     = LIMIT_RESET;
      expected_results.delete();
      errors  = 0;
      checked = 0;
      blends  = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_STREAM_ENABLE:    stream_on = cfg_data_i[0];
          CFG_TRANSITION_LIMIT: limit_ms  = cfg_data_i;
          default: ;
        endcase
      end
      if (res_valid_i && res_ready_i) begin
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 50) begin
            $display("%0t: result with no request waiting: level %0d rendered %0d total %0d",
                     $time, res_i.out_level, res_i.rendered, res_i.frame_total);
          end
        end else begin
          exp_res = expected_results.pop_front();
          check_field("out_level", 32'(exp_res.out_level), 32'(res_i.out_level));
          check_field("rendered", 32'(exp_res.rendered), 32'(res_i.rendered));
          check_field("frame_total", exp_res.frame_total, res_i.frame_total);
          checked++;
        end
      end
      if (req_valid_i && req_ready_i) begin
        expected_results.push_back(predict_result(req_i));
      end
    end
    // Counts reach the stimulus side through registered outputs.
    fail_count_o    <= errors;
    open_count_o    <= expected_results.size();
    checked_count_o <= checked;
    blend_count_o   <= blends;
  end

endmodule

[tb/sv/tb_frame_crossfade_sequencer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_frame_crossfade_sequencer
// Drives load, commit, render and clear requests into the frame crossfade
// sequencer under several register settings and idle patterns. A block of
// channels at both ends of every layer is filled in all three banks first,
// then a directed run covers the corner cases and random frame sequences
// follow. The checker beside the block judges results.
// ----------------------------------------------------------------------------
module tb_frame_crossfade_sequencer;
  import fcs_pkg::*;

  localparam int LAYER_COUNT = LAYER_COUNT_DEFAULT;
  localparam int CHANNELS    = CHANNELS_DEFAULT;
  localparam int PRE_CH      = 16;
  localparam logic [TIME_W-1:0] T0 = 32'hFFFF_FFF0;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [DUR_W-1:0]     cfg_data;

  int fail_count;
  int open_count;
  int checked_count;
  int blend_count;

  int                src_idle_pct   = 0;
  int                sink_stall_pct = 0;
  int unsigned       items_sent     = 0;
  int unsigned       op_count [4]   = '{0, 0, 0, 0};
  logic [TIME_W-1:0] clock_ms;

  fcs_stream_if #(.payload_t(fcs_in_t))  req_ch ();
  fcs_stream_if #(.payload_t(fcs_out_t)) res_ch ();

  always #5 clk = ~clk;

  frame_crossfade_sequencer #(
    .LAYER_COUNT(LAYER_COUNT),
    .CHANNELS   (CHANNELS)
  ) dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .in_i      (req_ch),
    .out_o     (res_ch),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  frame_crossfade_checker #(
    .LAYER_COUNT(LAYER_COUNT),
    .CHANNELS   (CHANNELS)
  ) u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .req_valid_i    (req_ch.valid),
    .req_ready_i    (req_ch.ready),
    .req_i          (req_ch.payload),
    .res_valid_i    (res_ch.valid),
    .res_ready_i    (res_ch.ready),
    .res_i          (res_ch.payload),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .fail_count_o   (fail_count),
    .open_count_o   (open_count),
    .checked_count_o(checked_count),
    .blend_count_o  (blend_count)
  );

  // Result side: stalls at random at the rate the current phase sets.
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      res_ch.ready <= rst_n && ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  initial begin
    #10_000_000;
    $display("Timeout with %0d results still outstanding.", open_count);
    $display("Simulation FAILED");
    $finish;
  end

  function automatic fcs_in_t random_req(input fcs_op_e op);
    fcs_in_t r;
    r.op          = op;
    r.layer       = 3'($urandom_range(0, 7));
    r.channel     = 8'($urandom_range(0, 255));
    r.level       = 8'($urandom_range(0, 255));
    r.duration_ms = 16'($urandom_range(0, 65535));
    r.now_ms      = $urandom();
    return r;
  endfunction

  // Channels that hold a level in every bank: the lowest and highest few.
  function automatic logic [7:0] covered_channel(input int k);
    if (k < PRE_CH / 2) return 8'(k);
    return 8'(CHANNELS - PRE_CH + k);
  endfunction

  function automatic logic [7:0] pick_channel();
    if ($urandom_range(0, 99) < 8) return 8'($urandom_range(CHANNELS, 255));
    return covered_channel($urandom_range(0, PRE_CH - 1));
  endfunction

  function automatic logic [DUR_W-1:0] pick_duration();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8)  return '0;
    if (r < 16) return 16'($urandom_range(0, 65535));
    if (r < 30) return 16'($urandom_range(1, 8));
    return 16'($urandom_range(1, 160));
  endfunction

  // A request stays offered until taken; the valid is only lowered for a gap.
  task automatic send_req(input fcs_in_t req);
    while (src_idle_pct > 0 && $urandom_range(0, 99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.payload <= req;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    op_count[req.op]++;
    items_sent++;
  endtask

  task automatic load_level(input int layer, input int channel, input int level);
    fcs_in_t r;
    r         = random_req(OP_LOAD);
    r.layer   = 3'(layer);
    r.channel = 8'(channel);
    r.level   = 8'(level);
    send_req(r);
  endtask

  task automatic commit_frame(input logic [DUR_W-1:0] dur, input logic [TIME_W-1:0] now);
    fcs_in_t r;
    r             = random_req(OP_COMMIT);
    r.duration_ms = dur;
    r.now_ms      = now;
    send_req(r);
  endtask

  task automatic render_at(input int layer, input int channel, input logic [TIME_W-1:0] now);
    fcs_in_t r;
    r         = random_req(OP_RENDER);
    r.layer   = 3'(layer);
    r.channel = 8'(channel);
    r.now_ms  = now;
    send_req(r);
  endtask

  task automatic clear_frames();
    send_req(random_req(OP_CLEAR));
  endtask

  // Holds requests back until every result is in, then lets the block settle.
  task automatic wait_drained();
    int guard;
    req_ch.valid <= 1'b0;
    @(posedge clk);
    for (guard = 0; guard < 20000 && open_count != 0; guard++) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_settings(input logic en, input logic [DUR_W-1:0] limit);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_STREAM_ENABLE;
    cfg_data <= {{(DUR_W-1){1'b0}}, en};
    @(posedge clk);
    cfg_idx  <= CFG_TRANSITION_LIMIT;
    cfg_data <= limit;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // Every in-range channel that is ever rendered gets a value in all three banks first.
  task automatic preload_banks();
    for (int pass = 0; pass < BANK_COUNT; pass++) begin
      for (int l = 0; l < LAYER_COUNT; l++) begin
        for (int c = 0; c < PRE_CH; c++) begin
          load_level(l, covered_channel(c), $urandom_range(0, 255));
        end
      end
      if (pass < BANK_COUNT - 1) commit_frame(16'($urandom_range(1, 100)), $urandom());
    end
    clear_frames();
  endtask

  task automatic directed_run();
    render_at(0, 0, '0);
    load_level(7, CHANNELS - 1, 255);
    load_level(0, 0, 0);
    load_level(3, 255, 8'hAA);
    commit_frame('0, T0);
    render_at(7, CHANNELS - 1, T0);
    render_at(2, CHANNELS, T0);
    load_level(7, CHANNELS - 1, 0);
    load_level(0, 0, 255);
    commit_frame(16'hFFFF, $urandom());
    render_at(7, CHANNELS - 1, T0);
    render_at(7, CHANNELS - 1, T0 + 1);
    load_level(5, 3, 200);
    commit_frame(16'd40, $urandom());
    render_at(5, 3, T0 + 21);
    render_at(5, 3, T0 + 80);
    render_at(5, 3, T0 + 81);
    commit_frame(16'd7, $urandom());
    // A time behind the phase start reads as a huge elapsed time.
    render_at(5, 3, T0 - 4);
    clear_frames();
    render_at(0, 0, T0);
    commit_frame(16'hFFFF, '0);
    render_at(7, CHANNELS - 1, 32'hFFFF_FFFF);
  endtask

  // Mostly a short frame: a few loads, a commit, then renders as time moves on.
  task automatic random_episode();
    int      n;
    fcs_in_t r;
    if ($urandom_range(0, 99) < 10) begin
      repeat (4) begin
        r         = random_req(fcs_op_e'($urandom_range(0, 3)));
        r.channel = pick_channel();
        send_req(r);
      end
    end
    if ($urandom_range(0, 99) < 3) clear_frames();
    if ($urandom_range(0, 99) < 4) wait_drained();
    n = $urandom_range(0, 10);
    repeat (n) load_level($urandom_range(0, 7), pick_channel(), $urandom_range(0, 255));
    commit_frame(pick_duration(), clock_ms);
    n = $urandom_range(1, 8);
    repeat (n) begin
      if ($urandom_range(0, 99) < 5) clock_ms = clock_ms + $urandom_range(0, 70000);
      else clock_ms = clock_ms + $urandom_range(0, 40);
      render_at($urandom_range(0, 7), pick_channel(),
                ($urandom_range(0, 99) < 3) ? $urandom() : clock_ms);
    end
  endtask

  task automatic run_phase(input logic en, input logic [DUR_W-1:0] limit, input int src_pct,
                           input int sink_pct, input int n_items);
    int unsigned target;
    wait_drained();
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    write_settings(en, limit);
    target = items_sent + n_items;
    while (items_sent < target) random_episode();
  endtask

  initial begin
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_idx        <= CFG_STREAM_ENABLE;
    cfg_data       <= '0;
    req_ch.valid   <= 1'b0;
    req_ch.payload <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_settings(1'b1, 16'd80);
    preload_banks();
    wait_drained();
    directed_run();

    clock_ms = 32'hFFFF_8000;
    run_phase(1'b1, 16'd80, 0, 0, 300);
    run_phase(1'b1, 16'd0, 59, 0, 200);
    run_phase(1'b1, 16'hFFFF, 0, 59, 250);
    run_phase(1'b0, 16'($urandom_range(1, 200)), 15, 15, 120);
    run_phase(1'b1, 16'($urandom_range(1, 300)), 15, 15, 270);
    run_phase(1'b1, 16'd1, 0, 0, 200);

    wait_drained();
    repeat (20) @(posedge clk);
    if (open_count != 0) $display("%0d expected results never arrived.", open_count);
    $display("Sent %0d requests: %0d loads, %0d commits, %0d renders, %0d clears.",
             items_sent, op_count[OP_LOAD], op_count[OP_COMMIT], op_count[OP_RENDER],
             op_count[OP_CLEAR]);
    $display("Compared %0d results over six register settings, %0d of them mid-crossfade.",
             checked_count, blend_count);
    if (fail_count == 0 && open_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[files.f]
rtl/fcs_pkg.sv
rtl/fcs_stream_if.sv
rtl/fcs_ram.sv
rtl/fcs_controller.sv
rtl/fcs_datapath.sv
rtl/frame_crossfade_sequencer.sv
rtl/fcs_checker.sv
tb/sv/frame_crossfade_checker.sv
tb/sv/tb_frame_crossfade_sequencer.sv
